@@ rtl/core/msb_first_hdlc_deframer_unit_defines.svh @@
// ----------------------------------------------------------------------------
// HDLC deframer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_HDLC_DEFRAMER_UNIT_DEFINES_SVH
`define MSB_FIRST_HDLC_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication
`define HDLCD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HDLCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/hdlcd_pkg.sv @@
// ----------------------------------------------------------------------------
// HDLC deframer package
// Types, codes and the CRC-16/X-25 byte update shared by the deframer files.
// ----------------------------------------------------------------------------
package hdlcd_pkg;

  localparam logic [23:0] FLAG_TRIPLE     = 24'h7E7E7E;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'h8408;
  localparam logic [15:0] MIN_FRAME_BYTES = 16'd3;
  localparam logic [15:0] LIMIT_RESET     = 16'd256;

  // verdict codes on a closing result
  localparam logic [1:0] VERDICT_GOOD    = 2'd0;
  localparam logic [1:0] VERDICT_PASSED  = 2'd1;
  localparam logic [1:0] VERDICT_DISCARD = 2'd2;

  // configuration register indexes
  localparam logic CFG_CRC_ENFORCE = 1'b0;
  localparam logic CFG_BYTE_LIMIT  = 1'b1;

  typedef enum logic [2:0] {
    MODE_HUNT  = 3'b001,
    MODE_SYNC  = 3'b010,
    MODE_FRAME = 3'b100
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [23:0] bit_window;
    logic [2:0]  ones_run;
    logic [7:0]  byte_assembly;
    logic [2:0]  bits_in_byte;
    logic [7:0]  lag_old;
    logic [7:0]  lag_new;
    logic [15:0] byte_count;
    logic [15:0] crc_accum;
    logic        saw_nonzero;
  } state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] payload_byte;
    logic       frame_close;
    logic [1:0] verdict;
  } result_t;

  // reflected CRC-16 update over one byte, lsb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/core/hdlcd_step.sv @@
// ----------------------------------------------------------------------------
// HDLC deframer bit step
// Next-state and result logic for one received bit: flag hunt, destuffing,
// byte assembly, two-byte lag, CRC update and the closing verdict.
// ----------------------------------------------------------------------------
module hdlcd_step (
  input  hdlcd_pkg::state_t  cur,
  input  logic               bit_in,
  input  logic               crc_enforce,
  input  logic [15:0]        frame_byte_limit,
  output hdlcd_pkg::state_t  nxt,
  output hdlcd_pkg::result_t res
);

  logic [2:0]  ones_inc;
  logic [7:0]  asm_byte;
  logic [15:0] count_inc;
  logic        crc_good;
  logic [1:0]  judge_verdict;
  logic        do_close;
  logic        do_hunt;
  logic        do_asm;
  logic [1:0]  close_verdict;

  assign ones_inc  = (cur.ones_run != 3'd7) ? cur.ones_run + 3'd1 : cur.ones_run;
  assign asm_byte  = {cur.byte_assembly[6:0], bit_in};
  assign count_inc = cur.byte_count + 16'd1;

  // check sequence verdict at a closing flag
  assign crc_good = cur.saw_nonzero && ((~cur.crc_accum) == {cur.lag_old, cur.lag_new});
  assign judge_verdict = (cur.byte_count < hdlcd_pkg::MIN_FRAME_BYTES) ?
                         hdlcd_pkg::VERDICT_DISCARD :
                         crc_good    ? hdlcd_pkg::VERDICT_GOOD :
                         crc_enforce ? hdlcd_pkg::VERDICT_DISCARD :
                                       hdlcd_pkg::VERDICT_PASSED;

  always_comb begin
    nxt            = cur;
    nxt.bit_window = {cur.bit_window[22:0], bit_in};
    res            = '0;
    do_close       = 1'b0;
    do_hunt        = 1'b0;
    do_asm         = 1'b0;
    close_verdict  = hdlcd_pkg::VERDICT_DISCARD;

    // mode decode
    unique case (cur.mode) inside
      hdlcd_pkg::MODE_HUNT: begin
        if (nxt.bit_window == hdlcd_pkg::FLAG_TRIPLE) begin
          nxt.mode          = hdlcd_pkg::MODE_SYNC;
          nxt.bit_window    = '0;
          nxt.ones_run      = '0;
          nxt.byte_assembly = '0;
          nxt.bits_in_byte  = '0;
          nxt.byte_count    = '0;
          nxt.crc_accum     = hdlcd_pkg::CRC_INIT;
          nxt.saw_nonzero   = 1'b0;
        end
      end
      hdlcd_pkg::MODE_SYNC, hdlcd_pkg::MODE_FRAME: begin
        if (bit_in) begin
          // seven ones: abort
          if (ones_inc == 3'd7) begin
            if (cur.mode == hdlcd_pkg::MODE_FRAME) begin
              do_close = 1'b1;
            end else begin
              do_hunt = 1'b1;
            end
          end else begin
            nxt.ones_run = ones_inc;
            do_asm       = 1'b1;
          end
        end else begin
          nxt.ones_run = '0;
          if (cur.ones_run == 3'd6) begin
            // flag seen
            if (cur.mode == hdlcd_pkg::MODE_FRAME) begin
              do_close      = 1'b1;
              close_verdict = judge_verdict;
            end else begin
              nxt.byte_assembly = '0;
              nxt.bits_in_byte  = '0;
            end
          end else if (cur.ones_run != 3'd5) begin
            // zero after five ones is a stuffed bit and is dropped
            do_asm = 1'b1;
          end
        end
      end
      default: do_hunt = 1'b1;
    endcase

    // byte assembly and lagged release
    if (do_asm) begin
      if (cur.bits_in_byte != 3'd7) begin
        nxt.byte_assembly = asm_byte;
        nxt.bits_in_byte  = cur.bits_in_byte + 3'd1;
      end else begin
        nxt.bits_in_byte  = '0;
        nxt.byte_assembly = '0;
        nxt.mode          = hdlcd_pkg::MODE_FRAME;
        nxt.byte_count    = count_inc;
        if (count_inc >= frame_byte_limit) begin
          do_close = 1'b1;
        end else begin
          if (count_inc >= hdlcd_pkg::MIN_FRAME_BYTES) begin
            res.valid        = 1'b1;
            res.payload_byte = cur.lag_old;
            nxt.crc_accum    = hdlcd_pkg::crc_feed(cur.crc_accum, cur.lag_old);
          end
          nxt.lag_old = cur.lag_new;
          nxt.lag_new = asm_byte;
          if (asm_byte != 8'h00) begin
            nxt.saw_nonzero = 1'b1;
          end
        end
      end
    end

    // closing result
    if (do_close) begin
      res.valid        = 1'b1;
      res.payload_byte = '0;
      res.frame_close  = 1'b1;
      res.verdict      = close_verdict;
      do_hunt          = 1'b1;
    end

    // back to flag hunt
    if (do_hunt) begin
      nxt.mode          = hdlcd_pkg::MODE_HUNT;
      nxt.bit_window    = '0;
      nxt.ones_run      = '0;
      nxt.byte_assembly = '0;
      nxt.bits_in_byte  = '0;
      nxt.byte_count    = '0;
    end
  end

endmodule

@@ rtl/core/msb_first_hdlc_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// MSB-first HDLC deframer
// One received bit per transaction in; destuffed payload bytes and one
// closing verdict per frame out, with the FCS held back two bytes.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        input      in_valid / in_stall    rx_bit
//  out       output     out_valid / out_stall  payload_byte, frame_close, verdict
//  cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One bit per cycle while the output is not stalled: an input register and
//  a result register with the bit step between them. rst is synchronous and
//  clears the deframer to flag hunt and the registers to crc_enforce 1,
//  frame_byte_limit 256. A stalled output holds its result; the input
//  register still takes one more bit behind it.
// ----------------------------------------------------------------------------
`include "msb_first_hdlc_deframer_unit_defines.svh"

module msb_first_hdlc_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        rx_bit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  payload_byte,
  output logic        frame_close,
  output logic [1:0]  verdict,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic               in_full;
  logic               in_bit;
  logic               advance;
  logic               process;
  logic               crc_enforce;
  logic [15:0]        frame_byte_limit;
  hdlcd_pkg::state_t  state;
  hdlcd_pkg::state_t  state_next;
  hdlcd_pkg::result_t res;

  // handshake
  assign advance   = !out_valid || !out_stall;
  assign process   = in_full && advance;
  assign in_stall  = in_full && !advance;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_enforce      <= 1'b1;
      frame_byte_limit <= hdlcd_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hdlcd_pkg::CFG_CRC_ENFORCE: crc_enforce      <= cfg_data[0];
        hdlcd_pkg::CFG_BYTE_LIMIT:  frame_byte_limit <= cfg_data;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (process) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_bit <= rx_bit;
    end
  end

  // bit step
  hdlcd_step u_step (
    .cur              (state),
    .bit_in           (in_bit),
    .crc_enforce      (crc_enforce),
    .frame_byte_limit (frame_byte_limit),
    .nxt              (state_next),
    .res              (res)
  );

  // deframer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode          <= hdlcd_pkg::MODE_HUNT;
      state.bit_window    <= '0;
      state.ones_run      <= '0;
      state.byte_assembly <= '0;
      state.bits_in_byte  <= '0;
      state.byte_count    <= '0;
      state.crc_accum     <= hdlcd_pkg::CRC_INIT;
      state.saw_nonzero   <= 1'b0;
    end else if (process) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= process && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      payload_byte <= res.payload_byte;
      frame_close  <= res.frame_close;
      verdict      <= res.verdict;
    end
  end

  // checks
  `HDLCD_ASSERT_IMP(a_close_fields, out_valid && frame_close, payload_byte == 8'h00 && verdict != 2'd3, "closing result carries a payload byte or a bad verdict")
  `HDLCD_ASSERT_IMP(a_payload_verdict, out_valid && !frame_close, verdict == hdlcd_pkg::VERDICT_GOOD, "payload result carries a verdict")
  `HDLCD_ASSERT_NEXT(a_close_hunts, process && res.frame_close, state.mode == hdlcd_pkg::MODE_HUNT, "deframer not hunting after a close")

endmodule

@@ bench/msb_first_hdlc_deframer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// MSB-first HDLC deframer testbench
// Drives a serial bit stream of flagged, stuffed frames, noise and aborts into
// the deframer. A bit-level deframing model inside a scoreboard class predicts
// every payload byte and closing verdict, and each output transaction is
// compared field by field, in order, across several register settings and
// handshake idling patterns.
// ----------------------------------------------------------------------------
module msb_first_hdlc_deframer_unit_tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 100;
  localparam int MAX_GAP       = 12;
  localparam int PHASE_BITS    = 100;

  typedef enum int {FR_GOOD, FR_BAD_FCS, FR_ABORT, FR_PARTIAL, FR_BARE} frame_kind_t;
  typedef enum int {FILL_MIX, FILL_ONES, FILL_ZERO} fill_t;

  typedef struct packed {
    bit [7:0] data;
    bit       close;
    bit [1:0] verdict;
  } deframe_out_t;

  // bit-level deframing model plus the queue of results it predicts
  class deframe_checker;
    bit                 enforce_crc;
    bit [15:0]          byte_limit;
    hdlcd_pkg::mode_t   mode;
    bit [23:0]          window;
    bit [2:0]           ones;
    bit [7:0]           shreg;
    bit [2:0]           nbits;
    bit [7:0]           lag_old;
    bit [7:0]           lag_new;
    bit [15:0]          nbytes;
    bit [15:0]          crc_acc;
    bit                 any_nonzero;
    deframe_out_t       pending[$];
    int unsigned        mismatches;

    function new();
      enforce_crc = 1'b1;
      byte_limit  = hdlcd_pkg::LIMIT_RESET;
      lag_old     = 8'h00;
      lag_new     = 8'h00;
      crc_acc     = hdlcd_pkg::CRC_INIT;
      any_nonzero = 1'b0;
      mismatches  = 0;
      enter_hunt();
    endfunction

    // x.25 fcs, one data bit at a time, lsb first
    static function bit [15:0] x25_update(bit [15:0] acc, bit [7:0] d);
      bit fb;
      for (int k = 0; k < 8; k++) begin
        fb  = acc[0] ^ d[k];
        acc = acc >> 1;
        if (fb) acc = acc ^ hdlcd_pkg::CRC_POLY;
      end
      return acc;
    endfunction

    // append one expected result transaction
    function void add_expected(bit [7:0] d, bit c, bit [1:0] v);
      deframe_out_t item;
      item.data    = d;
      item.close   = c;
      item.verdict = v;
      pending      = {pending, item};
    endfunction

    function void enter_hunt();
      mode   = hdlcd_pkg::MODE_HUNT;
      window = '0;
      ones   = '0;
      shreg  = '0;
      nbits  = '0;
      nbytes = '0;
    endfunction

    function void enter_sync();
      enter_hunt();
      mode        = hdlcd_pkg::MODE_SYNC;
      crc_acc     = hdlcd_pkg::CRC_INIT;
      any_nonzero = 1'b0;
    endfunction

    function void close_frame(bit [1:0] v);
      add_expected(8'h00, 1'b1, v);
      enter_hunt();
    endfunction

    function bit [1:0] frame_verdict();
      bit good;
      if (nbytes < hdlcd_pkg::MIN_FRAME_BYTES) return hdlcd_pkg::VERDICT_DISCARD;
      good = any_nonzero && ((crc_acc ^ 16'hFFFF) == {lag_old, lag_new});
      if (good) return hdlcd_pkg::VERDICT_GOOD;
      return enforce_crc ? hdlcd_pkg::VERDICT_DISCARD : hdlcd_pkg::VERDICT_PASSED;
    endfunction

    // advance the model by one accepted bit
    function void note_bit(bit b);
      bit [7:0] newest;
      window = {window[22:0], b};
      if (mode == hdlcd_pkg::MODE_HUNT) begin
        if (window == hdlcd_pkg::FLAG_TRIPLE) enter_sync();
        return;
      end
      // ones counting: abort, closing flag, stuffed zero
      if (b) begin
        if (ones != 3'd7) ones++;
        if (ones == 3'd7) begin
          if (mode == hdlcd_pkg::MODE_FRAME) close_frame(hdlcd_pkg::VERDICT_DISCARD);
          else enter_hunt();
          return;
        end
      end else begin
        if (ones == 3'd6) begin
          ones = '0;
          if (mode == hdlcd_pkg::MODE_SYNC) begin
            shreg = '0;
            nbits = '0;
          end else begin
            close_frame(frame_verdict());
          end
          return;
        end
        if (ones == 3'd5) begin
          ones = '0;
          return;
        end
        ones = '0;
      end
      // byte assembly, msb first
      shreg = {shreg[6:0], b};
      if (nbits != 3'd7) begin
        nbits++;
        return;
      end
      nbits  = '0;
      newest = shreg;
      shreg  = '0;
      mode   = hdlcd_pkg::MODE_FRAME;
      nbytes++;
      if (nbytes >= byte_limit) begin
        close_frame(hdlcd_pkg::VERDICT_DISCARD);
        return;
      end
      // release the byte two places back, it can no longer be fcs
      if (nbytes >= hdlcd_pkg::MIN_FRAME_BYTES) begin
        add_expected(lag_old, 1'b0, hdlcd_pkg::VERDICT_GOOD);
        crc_acc = x25_update(crc_acc, lag_old);
      end
      lag_old = lag_new;
      lag_new = newest;
      if (newest != 8'h00) any_nonzero = 1'b1;
    endfunction

    function void check_output(logic [7:0] pb, logic fc, logic [1:0] v);
      deframe_out_t want;
      if (pending.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: byte %02h close %0d verdict %0d", pb, fc, v);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (pb !== want.data || fc !== want.close || v !== want.verdict) begin
        if (mismatches < 10)
          $display({"result mismatch: expected byte %02h close %0d verdict %0d,",
                    " got byte %02h close %0d verdict %0d"},
                   want.data, want.close, want.verdict, pb, fc, v);
        mismatches++;
      end
    endfunction

    function void flush_leftovers();
      if (pending.size() != 0) begin
        if (mismatches < 10) $display("missing results: %0d never arrived", pending.size());
        mismatches++;
        pending.delete();
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        rx_bit;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  payload_byte;
  logic        frame_close;
  logic [1:0]  verdict;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  deframe_checker sb;
  int unsigned    bits_sent;
  int unsigned    results_seen;
  int             send_idle_pct;
  int             stall_pct;
  bit             hold_req;
  int             hold_left;
  int             stuff_run;

  msb_first_hdlc_deframer_unit uut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // receiver stall, with one long hold-off when requested
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // transaction monitor: model the accepted bit, then check any result
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_bit(rx_bit);
      if (out_valid && !out_stall) begin
        sb.check_output(payload_byte, frame_close, verdict);
        results_seen++;
      end
    end
  end

  // one bit transaction, with random idle cycles in front
  task automatic send_bit(input bit b);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_bit   <= b;
    do @(posedge clk); while (in_stall);
    bits_sent++;
  endtask

  // unstuffed bits, msb first
  task automatic send_raw(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) send_bit(v[i]);
  endtask

  task automatic send_flag();
    send_raw(32'h7E, 8);
    stuff_run = 0;
  endtask

  // top n bits of d with zero insertion after five ones
  task automatic send_data(input bit [7:0] d, input int n);
    for (int i = 7; i > 7 - n; i--) begin
      send_bit(d[i]);
      if (d[i]) begin
        stuff_run++;
        if (stuff_run == 5) begin
          send_bit(1'b0);
          stuff_run = 0;
        end
      end else begin
        stuff_run = 0;
      end
    end
  endtask

  function automatic bit [7:0] pick_byte(input fill_t fill);
    if (fill == FILL_ONES) return 8'hFF;
    if (fill == FILL_ZERO) return 8'h00;
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7E;
      3: return 8'hFC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // opening flags, optional junk and restart flag, body, fcs and ending
  task automatic send_frame(input frame_kind_t kind, input int len, input fill_t fill,
                            input int extra_flags, input int lead_bits);
    bit [7:0]  body[];
    bit [15:0] acc;
    bit [15:0] fcs;
    acc  = hdlcd_pkg::CRC_INIT;
    body = new[len];
    for (int i = 0; i < len; i++) begin
      body[i] = pick_byte(fill);
      acc     = deframe_checker::x25_update(acc, body[i]);
    end
    fcs = ~acc;
    if (kind == FR_BAD_FCS) fcs = fcs ^ (16'h1 << $urandom_range(0, 15));
    repeat (3 + extra_flags) send_flag();
    if (lead_bits > 0) begin
      send_raw($urandom, lead_bits);
      send_flag();
    end
    foreach (body[i]) send_data(body[i], 8);
    if (kind == FR_GOOD || kind == FR_BAD_FCS) begin
      send_data(fcs[15:8], 8);
      send_data(fcs[7:0], 8);
    end
    if (kind == FR_ABORT) begin
      send_raw(32'hFF, 8);
    end else begin
      if (kind == FR_PARTIAL) send_data(8'($urandom_range(0, 255)), $urandom_range(1, 7));
      send_flag();
    end
  endtask

  // one random frame or noise burst, then optional line fill
  task automatic random_traffic();
    int r;
    int len;
    int extra;
    int lead;
    r     = $urandom_range(0, 99);
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
    extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    lead  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0;
    if (r < 52)      send_frame(FR_GOOD, len, FILL_MIX, extra, lead);
    else if (r < 70) send_frame(FR_BAD_FCS, len, FILL_MIX, extra, lead);
    else if (r < 78) send_frame(FR_ABORT, len, FILL_MIX, extra, lead);
    else if (r < 84) send_frame(FR_PARTIAL, len, FILL_MIX, extra, lead);
    else if (r < 90) send_frame(FR_BARE, len, FILL_MIX, extra, lead);
    else             send_raw($urandom, $urandom_range(4, 32));
    case ($urandom_range(0, 3))
      1: send_raw(32'hFFFFFFFF, $urandom_range(1, 16));
      2: send_raw($urandom, $urandom_range(1, 12));
      default: ;
    endcase
  endtask

  task automatic write_cfg(input logic idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == hdlcd_pkg::CFG_CRC_ENFORCE) sb.enforce_crc = value[0];
    else sb.byte_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop sending and let every expected result drain out
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return 16'd3;
      1: return 16'($urandom_range(4, 10));
      2: return 16'd256;
      3: return 16'hFFFF;
      default: return 16'($urandom_range(3, 65535));
    endcase
  endfunction

  initial begin
    int unsigned start_bits;
    int          drain;
    sb            = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    rx_bit        = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = hdlcd_pkg::CFG_CRC_ENFORCE;
    cfg_data      = '0;
    bits_sent     = 0;
    results_seen  = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    stuff_run     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed frames, reset configuration, long receiver hold-off at the start
    hold_req = 1'b1;
    send_frame(FR_GOOD, 3, FILL_MIX, 1, 3);
    repeat (3) send_flag();
    send_raw(32'hFF, 8);
    send_frame(FR_ABORT, 1, FILL_MIX, 0, 0);
    send_frame(FR_PARTIAL, 1, FILL_MIX, 0, 0);
    send_frame(FR_BARE, 3, FILL_ZERO, 0, 0);
    settle();

    // bad fcs passed through, widest length limit
    write_cfg(hdlcd_pkg::CFG_CRC_ENFORCE, 16'd0);
    write_cfg(hdlcd_pkg::CFG_BYTE_LIMIT, 16'hFFFF);
    send_frame(FR_BAD_FCS, 2, FILL_ONES, 0, 0);
    settle();

    // smallest length limit
    write_cfg(hdlcd_pkg::CFG_BYTE_LIMIT, 16'd3);
    send_frame(FR_GOOD, 1, FILL_MIX, 0, 0);
    settle();

    // random traffic under each idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 58; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      write_cfg(hdlcd_pkg::CFG_CRC_ENFORCE, 16'($urandom_range(0, 1)));
      write_cfg(hdlcd_pkg::CFG_BYTE_LIMIT, pick_limit());
      start_bits = bits_sent;
      while (bits_sent - start_bits < PHASE_BITS)
        random_traffic();
      settle();
    end

    // final drain and verdict
    @(negedge clk);
    in_valid <= 1'b0;
    drain = 0;
    while (sb.pending.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.flush_leftovers();
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/hdlcd_pkg.sv
rtl/core/hdlcd_step.sv
rtl/core/msb_first_hdlc_deframer_unit.sv
bench/msb_first_hdlc_deframer_unit_tb.sv
